>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHECK_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CHECK_IMPLIES(label, clk, rst, ante, cons, msg)
`define CHECK_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> design/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Types, constants and command/status structs shared by the SHA-1 block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1md_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word0;
      logic [31:0] digest_word1;
      logic [31:0] digest_word2;
      logic [31:0] digest_word3;
      logic [31:0] digest_word4;
   } rsp_type;

   localparam logic [0:4][31:0] SHA1_IV = {
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_STAGE0 = 32'h5A827999;
   localparam logic [31:0] K_STAGE1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_STAGE2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_STAGE3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARKER = 8'h80;

   // byte positions inside a 64-byte block
   localparam logic [5:0] POS_LEN_START = 6'd56;
   localparam logic [5:0] POS_LAST      = 6'd63;

   // round sequencing
   localparam logic [6:0] ROUND_SCHED   = 7'd16;
   localparam logic [6:0] ROUND_STAGE1  = 7'd20;
   localparam logic [6:0] ROUND_STAGE2  = 7'd40;
   localparam logic [6:0] ROUND_STAGE3  = 7'd60;
   localparam logic [6:0] ROUND_LAST    = 7'd79;

   // round stage codes
   localparam logic [1:0] STAGE_CH     = 2'd0;
   localparam logic [1:0] STAGE_PAR1   = 2'd1;
   localparam logic [1:0] STAGE_MAJ    = 2'd2;
   localparam logic [1:0] STAGE_PAR2   = 2'd3;

   // byte source select
   localparam logic [1:0] SEL_DATA   = 2'd0;
   localparam logic [1:0] SEL_MARKER = 2'd1;
   localparam logic [1:0] SEL_ZERO   = 2'd2;
   localparam logic [1:0] SEL_LENGTH = 2'd3;

   typedef struct packed {
      logic       put_en;     // shift one byte into the block line
      logic [1:0] put_sel;
      logic       count_len;  // message byte: bump the bit count
      logic       load_work;  // copy chain value into a..e
      logic       round_en;
      logic [1:0] stage;
      logic       sched_new;  // expand a new schedule word
      logic       add_en;     // fold a..e into the chain value
      logic       emit;       // capture digest, restart the message
   } cmd_type;

   typedef struct packed {
      logic [5:0] block_pos;
   } status_type;

   function automatic logic [31:0] round_const(input logic [1:0] stage);
      logic [31:0] k;
      case (stage)
         STAGE_CH:   k = K_STAGE0;
         STAGE_PAR1: k = K_STAGE1;
         STAGE_MAJ:  k = K_STAGE2;
         default:    k = K_STAGE3;
      endcase
      return k;
   endfunction

endpackage

>>> design/sha1md_datapath.sv
// ----------------------------------------------------------------------------
// sha1md_datapath
// Block shift line, round unit, chain value, bit count and digest register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1md_datapath
   import sha1md_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic [7:0] req_byte,
   output status_type status,
   output rsp_type    rsp_data
);

   function automatic logic [31:0] rotl1(input logic [31:0] x);
      return {x[30:0], x[31]};
   endfunction

   function automatic logic [31:0] rotl5(input logic [31:0] x);
      return {x[26:0], x[31:27]};
   endfunction

   function automatic logic [31:0] rotl30(input logic [31:0] x);
      return {x[1:0], x[31:2]};
   endfunction

   // 64-byte line; oldest byte / word sits at the top
   logic [511:0]        block_ff, block_in;
   logic [0:4][31:0]    chain_ff, chain_in;
   logic [0:4][31:0]    work_ff, work_in;
   logic [5:0]          pos_ff, pos_in;
   logic [63:0]         len_ff, len_in;
   rsp_type             rsp_ff, rsp_in;

   logic [7:0]  put_byte;
   logic [63:0] len_shift;
   logic [31:0] w0, w2, w8, w13, sched, f_val, t_val;

   assign len_shift = len_ff >> {~pos_ff[2:0], 3'b000};

   always_comb begin
      case (cmd.put_sel)
         SEL_DATA:   put_byte = req_byte;
         SEL_MARKER: put_byte = PAD_MARKER;
         SEL_LENGTH: put_byte = len_shift[7:0];
         default:    put_byte = 8'h00;
      endcase
   end

   assign w0  = block_ff[511:480];
   assign w2  = block_ff[447:416];
   assign w8  = block_ff[255:224];
   assign w13 = block_ff[95:64];
   assign sched = cmd.sched_new ? rotl1(w13 ^ w8 ^ w2 ^ w0) : w0;

   always_comb begin
      case (cmd.stage)
         STAGE_CH:  f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         STAGE_MAJ: f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3]) |
                            (work_ff[2] & work_ff[3]);
         default:   f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
      endcase
   end

   assign t_val = rotl5(work_ff[0]) + f_val + work_ff[4] + sched + round_const(cmd.stage);

   always_comb begin
      block_in = block_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      work_in  = work_ff;
      chain_in = chain_ff;
      rsp_in   = rsp_ff;
      if (cmd.put_en) begin
         block_in = {block_ff[503:0], put_byte};
         pos_in   = pos_ff + 6'd1;
      end
      if (cmd.count_len) begin
         len_in = len_ff + 64'd8;
      end
      if (cmd.round_en) begin
         block_in = {block_ff[479:0], sched};
         work_in  = {t_val, work_ff[0], rotl30(work_ff[1]), work_ff[2], work_ff[3]};
      end
      if (cmd.load_work) begin
         work_in = chain_ff;
      end
      if (cmd.add_en) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.emit) begin
         rsp_in   = {chain_ff[0], chain_ff[1], chain_ff[2], chain_ff[3], chain_ff[4]};
         chain_in = SHA1_IV;
         pos_in   = '0;
         len_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= SHA1_IV;
         pos_ff   <= '0;
         len_ff   <= '0;
      end else begin
         chain_ff <= chain_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      work_ff  <= work_in;
      rsp_ff   <= rsp_in;
   end

   assign status.block_pos = pos_ff;
   assign rsp_data         = rsp_ff;

endmodule

>>> design/sha1md_control.sv
// ----------------------------------------------------------------------------
// sha1md_control
// Sequencer: byte intake, padding, 80-round schedule, digest handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha1md_control
   import sha1md_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_ROUND = 3'd2;
   localparam logic [2:0] S_ADD   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [6:0] round_ff, round_in;
   logic       pad_first_ff, pad_first_in;   // 0x80 not yet placed
   logic       len_phase_ff, len_phase_in;   // writing the length field
   logic       last_ff, last_in;             // padding owed after this block
   logic       final_ff, final_in;           // this block closes the message
   logic       rsp_valid_ff, rsp_valid_in;

   logic [1:0] pad_sel;

   always_comb begin
      if (pad_first_ff) begin
         pad_sel = SEL_MARKER;
      end else if (len_phase_ff || status.block_pos == POS_LEN_START) begin
         pad_sel = SEL_LENGTH;
      end else begin
         pad_sel = SEL_ZERO;
      end
   end

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      pad_first_in = pad_first_ff;
      len_phase_in = len_phase_ff;
      last_in      = last_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.put_sel  = SEL_DATA;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.put_en    = req_data.has_byte;
               cmd.count_len = req_data.has_byte;
               pad_first_in  = 1'b1;
               len_phase_in  = 1'b0;
               last_in       = req_data.last;
               final_in      = 1'b0;
               if (req_data.has_byte && status.block_pos == POS_LAST) begin
                  cmd.load_work = 1'b1;
                  round_in      = '0;
                  state_in      = S_ROUND;
               end else if (req_data.last) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            cmd.put_en  = 1'b1;
            cmd.put_sel = pad_sel;
            if (pad_sel == SEL_MARKER) begin
               pad_first_in = 1'b0;
            end
            if (pad_sel == SEL_LENGTH) begin
               len_phase_in = 1'b1;
            end
            if (status.block_pos == POS_LAST) begin
               cmd.load_work = 1'b1;
               round_in      = '0;
               final_in      = (pad_sel == SEL_LENGTH);
               state_in      = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round_en  = 1'b1;
            cmd.sched_new = (round_ff >= ROUND_SCHED);
            if (round_ff < ROUND_STAGE1) begin
               cmd.stage = STAGE_CH;
            end else if (round_ff < ROUND_STAGE2) begin
               cmd.stage = STAGE_PAR1;
            end else if (round_ff < ROUND_STAGE3) begin
               cmd.stage = STAGE_MAJ;
            end else begin
               cmd.stage = STAGE_PAR2;
            end
            round_in = round_ff + 7'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.add_en = 1'b1;
            if (final_ff) begin
               state_in = S_EMIT;
            end else if (last_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               last_in      = 1'b0;
               final_in     = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         round_ff     <= '0;
         pad_first_ff <= 1'b1;
         len_phase_ff <= 1'b0;
         last_ff      <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         pad_first_ff <= pad_first_in;
         len_phase_ff <= len_phase_in;
         last_ff      <= last_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `CHECK_IMPLIES(a_round_range, clock, reset, state_ff == S_ROUND, round_ff <= ROUND_LAST, "round index past last round")
   `CHECK_IMPLIES(a_add_after_rounds, clock, reset, state_ff == S_ADD, $past(state_ff) == S_ROUND && $past(round_ff) == ROUND_LAST, "chain add without full round sequence")
   `CHECK_IMPLIES(a_emit_no_overwrite, clock, reset, cmd.emit, !rsp_valid_ff || rsp_ready, "digest overwritten before taken")
   `CHECK_IMPLIES(a_len_after_marker, clock, reset, len_phase_ff, !pad_first_ff, "length field before pad marker")
   `CHECK_NEXT(a_block_start, clock, reset, cmd.load_work, state_ff == S_ROUND && round_ff == 7'd0, "compression did not start at round zero")

endmodule

>>> design/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 hash of a byte stream, one byte per request, digest on the last one.
// ----------------------------------------------------------------------------
// Each request carries at most one message byte; a request with last set
// closes the message (with or without a byte) and yields one 160-bit digest
// on the rsp channel, after which a new message starts. A byte that completes
// a 64-byte block is taken in and starts a compression: 80 rounds through the
// single round unit at one round per cycle, then a fold of the result into the
// chain value; no new request is accepted until that is done. Closing a message
// feeds the padding and length bytes one per cycle (9 to 72 bytes), runs one
// or two compressions, and then loads the digest register once any earlier
// digest has been taken. The digest register lets the next message start
// while a digest waits to be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_message_digest
   import sha1md_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   sha1md_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sha1md_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_byte (req_data.data_byte),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
